[design/audio_capture_session_fsm_unit_defines.svh]
// Assertion macros for the capture session checker.
`ifndef AUDIO_CAPTURE_SESSION_FSM_UNIT_DEFINES_SVH
`define AUDIO_CAPTURE_SESSION_FSM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/acsf_pkg.sv]
// Shared types and constants for the capture session state machine.
package acsf_pkg;

  typedef enum logic [3:0] {
    CMD_HELLO       = 4'd0,
    CMD_START       = 4'd1,
    CMD_KEEPALIVE   = 4'd2,
    CMD_ABORT       = 4'd3,
    CMD_END         = 4'd4,
    CMD_STARTED     = 4'd5,
    CMD_PCM         = 4'd6,
    CMD_TICK        = 4'd7,
    CMD_ENDED       = 4'd8,
    CMD_LOCAL_ABORT = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_ACCEPT  = 2'd1,
    ST_ERROR   = 2'd2,
    ST_DUP_END = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_LEASE_TIMEOUT = 2'd0,
    REG_MAX_DURATION  = 2'd1,
    REG_MAX_TOTAL     = 2'd2,
    REG_MAX_CHUNK     = 2'd3
  } cfg_reg_t;

  // Phase coding as seen on the result channel
  localparam logic [2:0] PH_UNBOUND   = 3'd0;
  localparam logic [2:0] PH_IDLE      = 3'd1;
  localparam logic [2:0] PH_STARTING  = 3'd2;
  localparam logic [2:0] PH_CAPTURING = 3'd3;
  localparam logic [2:0] PH_DRAINING  = 3'd4;

  localparam logic [31:0] LEASE_TIMEOUT_RST = 32'd5000;
  localparam logic [31:0] MAX_DURATION_RST  = 32'd60000;
  localparam logic [31:0] MAX_TOTAL_RST     = 32'd1920000;
  localparam logic [15:0] MAX_CHUNK_RST     = 16'd4096;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] frame_generation;
    logic [31:0] frame_capture_id;
    logic [63:0] now_ms;
    logic [15:0] chunk_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  phase_now;
    logic        ended_flag;
    logic [31:0] byte_total;
    logic [31:0] chunk_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] lease_timeout_ms;
    logic [31:0] max_duration_ms;
    logic [31:0] max_total_bytes;
    logic [15:0] max_chunk_bytes;
  } cfg_t;

endpackage

[design/acsf_core.sv]
// Session state, per-event next-state logic and the result register.
module acsf_core
  import acsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  typedef enum logic [2:0] {
    S_UNBOUND   = PH_UNBOUND,
    S_IDLE      = PH_IDLE,
    S_STARTING  = PH_STARTING,
    S_CAPTURING = PH_CAPTURING,
    S_DRAINING  = PH_DRAINING
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [31:0] gen_r,     gen_nxt;
  logic [31:0] cur_cap_r, cur_cap_nxt;
  logic [31:0] new_cap_r, new_cap_nxt;
  logic        ended_r,   ended_nxt;
  logic [31:0] bytes_r,   bytes_nxt;
  logic [31:0] chunks_r,  chunks_nxt;
  logic [63:0] lease_r,   lease_nxt;
  logic [63:0] start_r,   start_nxt;
  out_item_t   result_r;
  status_t     status;

  logic [63:0] lease_age;
  logic [63:0] run_age;
  logic        lease_expired;
  logic        duration_hit;
  logic        frame_ok;
  logic [31:0] chunk_ext;
  logic [31:0] room;
  logic        chunk_ok;

  assign lease_age     = item.now_ms - lease_r;
  assign run_age       = item.now_ms - start_r;
  assign lease_expired = lease_age >= {32'd0, cfg.lease_timeout_ms};
  assign duration_hit  = run_age >= {32'd0, cfg.max_duration_ms};
  assign frame_ok      = (item.frame_generation == gen_r) && (gen_r != 32'd0);
  assign chunk_ext     = {16'd0, item.chunk_bytes};
  assign room          = cfg.max_total_bytes - bytes_r;
  assign chunk_ok      = (item.chunk_bytes != 16'd0) && !item.chunk_bytes[0] &&
                         (item.chunk_bytes <= cfg.max_chunk_bytes) &&
                         (bytes_r <= cfg.max_total_bytes) && (chunk_ext <= room);

  always_comb begin
    phase_nxt   = phase_r;
    gen_nxt     = gen_r;
    cur_cap_nxt = cur_cap_r;
    new_cap_nxt = new_cap_r;
    ended_nxt   = ended_r;
    bytes_nxt   = bytes_r;
    chunks_nxt  = chunks_r;
    lease_nxt   = lease_r;
    start_nxt   = start_r;
    status      = ST_NONE;
    case (item.cmd)
      CMD_HELLO: begin
        if (item.frame_generation == gen_r) begin
          status = (phase_r == S_IDLE) ? ST_ACCEPT : ST_NONE;
        end else begin
          // new generation: drop the whole session and bind
          phase_nxt   = S_IDLE;
          gen_nxt     = item.frame_generation;
          cur_cap_nxt = '0;
          new_cap_nxt = '0;
          ended_nxt   = 1'b0;
          bytes_nxt   = '0;
          chunks_nxt  = '0;
          lease_nxt   = '0;
          start_nxt   = '0;
          status      = ST_ACCEPT;
        end
      end
      CMD_START: begin
        priority if (!frame_ok || (item.frame_capture_id <= new_cap_r)) begin
          status = ST_NONE;
        end else if (phase_r != S_IDLE) begin
          status = ST_ERROR;
        end else begin
          phase_nxt   = S_STARTING;
          cur_cap_nxt = item.frame_capture_id;
          new_cap_nxt = item.frame_capture_id;
          chunks_nxt  = '0;
          bytes_nxt   = '0;
          ended_nxt   = 1'b0;
          lease_nxt   = item.now_ms;
          status      = ST_ACCEPT;
        end
      end
      CMD_KEEPALIVE, CMD_ABORT, CMD_END: begin
        priority if (!frame_ok || (item.frame_capture_id != cur_cap_r)) begin
          status = ST_NONE;
        end else if ((item.cmd == CMD_END) && ended_r) begin
          status = ST_DUP_END;
        end else if ((item.cmd == CMD_END) && (phase_r == S_DRAINING)) begin
          status = ST_NONE;
        end else if ((phase_r == S_IDLE) || (phase_r == S_UNBOUND)) begin
          status = ST_NONE;
        end else if (item.cmd == CMD_KEEPALIVE) begin
          lease_nxt = item.now_ms;
          status    = ST_ACCEPT;
        end else if (item.cmd == CMD_ABORT) begin
          phase_nxt  = (gen_r != 32'd0) ? S_IDLE : S_UNBOUND;
          ended_nxt  = 1'b0;
          bytes_nxt  = '0;
          chunks_nxt = '0;
          status     = ST_ACCEPT;
        end else if (phase_r == S_CAPTURING) begin
          phase_nxt = S_DRAINING;
          status    = ST_ACCEPT;
        end else begin
          status = ST_ERROR;
        end
      end
      CMD_STARTED: begin
        if ((phase_r == S_STARTING) && !lease_expired) begin
          phase_nxt = S_CAPTURING;
          start_nxt = item.now_ms;
          status    = ST_ACCEPT;
        end
      end
      CMD_PCM: begin
        if (((phase_r == S_CAPTURING) || (phase_r == S_DRAINING)) && chunk_ok) begin
          bytes_nxt  = bytes_r + chunk_ext;
          chunks_nxt = chunks_r + 32'd1;
          status     = ST_ACCEPT;
        end
      end
      CMD_TICK: begin
        priority if ((phase_r == S_IDLE) || (phase_r == S_UNBOUND)) begin
          status = ST_NONE;
        end else if (lease_expired) begin
          status = ST_ERROR;
        end else if ((phase_r == S_CAPTURING) &&
                     ((bytes_r >= cfg.max_total_bytes) || duration_hit)) begin
          phase_nxt = S_DRAINING;
          status    = ST_ACCEPT;
        end else begin
          status = ST_NONE;
        end
      end
      CMD_ENDED: begin
        phase_nxt = S_IDLE;
        ended_nxt = 1'b1;
      end
      CMD_LOCAL_ABORT: begin
        phase_nxt  = (gen_r != 32'd0) ? S_IDLE : S_UNBOUND;
        ended_nxt  = 1'b0;
        bytes_nxt  = '0;
        chunks_nxt = '0;
      end
      default: begin
        status = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= S_UNBOUND;
      gen_r     <= '0;
      cur_cap_r <= '0;
      new_cap_r <= '0;
      ended_r   <= 1'b0;
      bytes_r   <= '0;
      chunks_r  <= '0;
      lease_r   <= '0;
      start_r   <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      gen_r     <= gen_nxt;
      cur_cap_r <= cur_cap_nxt;
      new_cap_r <= new_cap_nxt;
      ended_r   <= ended_nxt;
      bytes_r   <= bytes_nxt;
      chunks_r  <= chunks_nxt;
      lease_r   <= lease_nxt;
      start_r   <= start_nxt;
      result_r  <= '{status:      status,
                     phase_now:   phase_nxt,
                     ended_flag:  ended_nxt,
                     byte_total:  bytes_nxt,
                     chunk_count: chunks_nxt};
    end
  end

  assign result = result_r;

endmodule

[design/audio_capture_session_fsm_unit.sv]
// out_valid rises once an accepted input transaction has passed the input register and
// then the result register.
// Throughput: one transaction per cycle unless out_ready holds a result; the event is
// decoded against session state between the input register and the result register.
// Reset (rst_n low, synchronous): both stages empty, phase unbound, all session state zero,
// limit registers at their defaults; cfg_ready stays high.
module audio_capture_session_fsm_unit
  import acsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // limit register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Input stage: holds one event until the result register can take its outcome.
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  logic      s1_adv;
  cfg_t      cfg_r;

  // Advance the held event when the result register is empty or being drained.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  // Register writes never stall.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      // a new result replaces a taken one; otherwise drop valid once taken
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // Limit registers; the host must only write them while no event is in flight (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lease_timeout_ms <= LEASE_TIMEOUT_RST;
      cfg_r.max_duration_ms  <= MAX_DURATION_RST;
      cfg_r.max_total_bytes  <= MAX_TOTAL_RST;
      cfg_r.max_chunk_bytes  <= MAX_CHUNK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEASE_TIMEOUT: cfg_r.lease_timeout_ms <= cfg_data;
        REG_MAX_DURATION:  cfg_r.max_duration_ms  <= cfg_data;
        REG_MAX_TOTAL:     cfg_r.max_total_bytes  <= cfg_data;
        REG_MAX_CHUNK:     cfg_r.max_chunk_bytes  <= cfg_data[15:0];
      endcase
    end
  end

  // Session state and the result register; state commits as the event leaves stage 1.
  acsf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (out_data)
  );

endmodule

[design/acsf_checker.sv]
// Port-level checker for the capture session unit, bound to the top level.
`include "audio_capture_session_fsm_unit_defines.svh"

module acsf_checker
  import acsf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic held;
  logic no_counts;
  logic dup_out;
  logic unbound_out;
  logic starting_out;
  logic clear_out;

  assign held         = out_valid && !out_ready;
  assign no_counts    = (out_data.byte_total == 32'd0) && (out_data.chunk_count == 32'd0);
  assign dup_out      = out_valid && (out_data.status == ST_DUP_END);
  assign unbound_out  = out_valid && (out_data.phase_now == PH_UNBOUND);
  assign starting_out = out_valid && (out_data.phase_now == PH_STARTING);
  assign clear_out    = no_counts && !out_data.ended_flag;

  `ACSF_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_data), "stalled result changed")
  `ACSF_ASSERT_IMPL(a_phase_code, out_valid, out_data.phase_now <= PH_DRAINING, "bad phase code")
  `ACSF_ASSERT_IMPL(a_dup_end, dup_out, out_data.ended_flag, "duplicate end without ended mark")
  `ACSF_ASSERT_IMPL(a_unbound_clear, unbound_out, clear_out, "unbound phase with capture state")
  `ACSF_ASSERT_IMPL(a_starting_clear, starting_out, clear_out, "starting phase with counts")

endmodule

bind audio_capture_session_fsm_unit acsf_checker u_acsf_checker (.*);
